// File: hw/rtl/rgb_led_blink_pattern_sequencer_macros.svh
// ----------------------------------------------------------------------------
// rgb led sequencer assertion macros
// Shared concurrent assertion helpers, clocked on i_clk with i_rst_n reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_BLINK_PATTERN_SEQUENCER_MACROS_SVH
`define RGB_LED_BLINK_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication
`define RLBPS_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("rlbps assertion failed");

// next-cycle implication
`define RLBPS_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("rlbps assertion failed");

`endif

// File: hw/rtl/rlbps_pkg.sv
// ----------------------------------------------------------------------------
// rlbps_pkg
// Types and constants shared by the rgb led blink pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rlbps_pkg;

    localparam int TIME_W     = 32;
    localparam int LEN_W      = 16;
    localparam int RGB_W      = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int INTERVAL_W = 9;

    // ceil(320*elapsed/length): numerator below 2^25, quotient at most 320
    localparam int DIVIDEND_W = 25;
    localparam int QUOT_W     = 9;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam logic [INTERVAL_W-1:0] CD_START_MS = INTERVAL_W'(400);
    localparam logic [QUOT_W-1:0]     CD_SPAN_MS  = QUOT_W'(320);
    localparam logic [INTERVAL_W-1:0] CD_MIN_MS   = INTERVAL_W'(80);
    localparam logic [INTERVAL_W-1:0] SUCCESS_MS  = INTERVAL_W'(250);
    localparam logic [INTERVAL_W-1:0] ERROR_MS    = INTERVAL_W'(500);

    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_SOLID     = 3'd1;
    localparam logic [2:0] REQ_OFF       = 3'd2;
    localparam logic [2:0] REQ_COUNTDOWN = 3'd3;
    localparam logic [2:0] REQ_SUCCESS   = 3'd4;
    localparam logic [2:0] REQ_ERROR     = 3'd5;

    localparam logic [CFG_ADDR_W-1:0] CFG_WHITE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_GREEN = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_BLUE  = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_RED   = CFG_ADDR_W'(3);

    localparam logic [RGB_W-1:0] WHITE_RST = 24'hFFFFFF;
    localparam logic [RGB_W-1:0] GREEN_RST = 24'h00FF00;
    localparam logic [RGB_W-1:0] BLUE_RST  = 24'h0000FF;
    localparam logic [RGB_W-1:0] RED_RST   = 24'hFF0000;

    typedef enum logic [1:0] {
        MODE_NONE      = 2'd0,
        MODE_COUNTDOWN = 2'd1,
        MODE_SUCCESS   = 2'd2,
        MODE_ERROR     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_TOGGLE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [LEN_W-1:0] duration_ms;
        logic [7:0]       solid_r;
        logic [7:0]       solid_g;
        logic [7:0]       solid_b;
    } t_in_req;

    typedef struct packed {
        logic [7:0] led_r;
        logic [7:0] led_g;
        logic [7:0] led_b;
        logic       color_written;
        logic       pattern_active;
    } t_out_rsp;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [LEN_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/rlbps_divider.sv
// ----------------------------------------------------------------------------
// rlbps_divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbps_divider (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rlbps_pkg::t_div_req i_req,
    output rlbps_pkg::t_div_rsp      o_rsp
);

    logic [rlbps_pkg::DIVIDEND_W-1:0] r_num;
    logic [rlbps_pkg::LEN_W-1:0]      r_rem;
    logic [rlbps_pkg::LEN_W-1:0]      r_dvs;
    logic [rlbps_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                             r_busy;
    logic                             r_done;

    logic [rlbps_pkg::LEN_W:0]   rem_sh;
    logic [rlbps_pkg::LEN_W+1:0] diff;

    assign rem_sh = {r_rem, r_num[rlbps_pkg::DIVIDEND_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= rlbps_pkg::DIV_CNT_W'(rlbps_pkg::DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in from the bottom as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[rlbps_pkg::DIVIDEND_W-2:0], ~diff[rlbps_pkg::LEN_W+1]};
            r_rem <= diff[rlbps_pkg::LEN_W+1] ? rem_sh[rlbps_pkg::LEN_W-1:0]
                                              : diff[rlbps_pkg::LEN_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num[rlbps_pkg::QUOT_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/rgb_led_blink_pattern_sequencer.sv
// flow: a countdown tick that reaches the interval check passes EVAL, the 25-step
// serial divider in DIV, TOGGLE and DONE; other requests skip DIV and end in DONE
// handshake: one request at a time, the next is taken once the previous has moved
// into the output register, which waits while the output is held off
// reset: synchronous active low, clears clock, pattern state and led, restores palette
// ----------------------------------------------------------------------------
// rgb_led_blink_pattern_sequencer
// Drives one rgb led from millisecond ticks and solid, off and blink requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_led_blink_pattern_sequencer_macros.svh"

module rgb_led_blink_pattern_sequencer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire rlbps_pkg::t_in_req                  i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output rlbps_pkg::t_out_rsp                      o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [rlbps_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [rlbps_pkg::RGB_W-1:0]         i_cfg_data
);

    rlbps_pkg::t_state  r_state, n_state;
    rlbps_pkg::t_in_req r_req, n_req;
    rlbps_pkg::t_mode   r_mode, n_mode;
    rlbps_pkg::t_out_rsp r_out, n_out;

    logic [rlbps_pkg::TIME_W-1:0]     r_clock, n_clock;
    logic [rlbps_pkg::TIME_W-1:0]     r_start, n_start;
    logic [rlbps_pkg::TIME_W-1:0]     r_last, n_last;
    logic [rlbps_pkg::LEN_W-1:0]      r_length, n_length;
    logic                             r_toggle, n_toggle;
    logic [rlbps_pkg::RGB_W-1:0]      r_shown, n_shown;
    logic [rlbps_pkg::INTERVAL_W-1:0] r_interval, n_interval;
    logic                             r_written, n_written;
    logic                             r_out_valid, n_out_valid;
    logic [rlbps_pkg::RGB_W-1:0]      r_white, n_white;
    logic [rlbps_pkg::RGB_W-1:0]      r_green, n_green;
    logic [rlbps_pkg::RGB_W-1:0]      r_blue, n_blue;
    logic [rlbps_pkg::RGB_W-1:0]      r_red, n_red;

    logic [rlbps_pkg::TIME_W-1:0]     elapsed;
    logic [rlbps_pkg::TIME_W-1:0]     since;
    logic                             expired;
    logic [rlbps_pkg::DIVIDEND_W-1:0] scaled;
    rlbps_pkg::t_div_req              div_req;
    rlbps_pkg::t_div_rsp              div_rsp;

    rlbps_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign elapsed = r_clock - r_start;
    assign since   = r_clock - r_last;
    assign expired = elapsed >= {{(rlbps_pkg::TIME_W-rlbps_pkg::LEN_W){1'b0}}, r_length};

    // 320*e = 256*e + 64*e, plus length-1 for the ceiling
    assign scaled = {1'b0, elapsed[rlbps_pkg::LEN_W-1:0], 8'b0}
                  + {3'b000, elapsed[rlbps_pkg::LEN_W-1:0], 6'b0}
                  + {{(rlbps_pkg::DIVIDEND_W-rlbps_pkg::LEN_W){1'b0}}, r_length}
                  - rlbps_pkg::DIVIDEND_W'(1);

    assign o_in_ready  = (r_state == rlbps_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_mode      = r_mode;
        n_out       = r_out;
        n_clock     = r_clock;
        n_start     = r_start;
        n_last      = r_last;
        n_length    = r_length;
        n_toggle    = r_toggle;
        n_shown     = r_shown;
        n_interval  = r_interval;
        n_written   = r_written;
        n_out_valid = r_out_valid;
        n_white     = r_white;
        n_green     = r_green;
        n_blue      = r_blue;
        n_red       = r_red;

        div_req.start    = 1'b0;
        div_req.dividend = scaled;
        div_req.divisor  = r_length;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_addr)
                rlbps_pkg::CFG_WHITE: n_white = i_cfg_data;
                rlbps_pkg::CFG_GREEN: n_green = i_cfg_data;
                rlbps_pkg::CFG_BLUE:  n_blue  = i_cfg_data;
                rlbps_pkg::CFG_RED:   n_red   = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            rlbps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = rlbps_pkg::ST_EVAL;
                    if (i_in.req_type == rlbps_pkg::REQ_TICK) begin
                        n_clock = r_clock + 1'b1;
                    end
                end
            end
            rlbps_pkg::ST_EVAL: begin
                n_written = 1'b0;
                n_state   = rlbps_pkg::ST_DONE;
                case (r_req.req_type)
                    rlbps_pkg::REQ_TICK: begin
                        if (r_mode == rlbps_pkg::MODE_NONE) begin
                            n_written = 1'b0;
                        end else if ((r_mode inside {rlbps_pkg::MODE_COUNTDOWN,
                                                     rlbps_pkg::MODE_SUCCESS}) && expired) begin
                            n_mode    = rlbps_pkg::MODE_NONE;
                            n_shown   = '0;
                            n_written = 1'b1;
                        end else if (r_mode == rlbps_pkg::MODE_COUNTDOWN) begin
                            div_req.start = 1'b1;
                            n_state       = rlbps_pkg::ST_DIV;
                        end else begin
                            n_interval = (r_mode == rlbps_pkg::MODE_SUCCESS)
                                       ? rlbps_pkg::SUCCESS_MS : rlbps_pkg::ERROR_MS;
                            n_state    = rlbps_pkg::ST_TOGGLE;
                        end
                    end
                    rlbps_pkg::REQ_SOLID: begin
                        n_mode    = rlbps_pkg::MODE_NONE;
                        n_shown   = {r_req.solid_r, r_req.solid_g, r_req.solid_b};
                        n_written = 1'b1;
                    end
                    rlbps_pkg::REQ_OFF: begin
                        n_mode    = rlbps_pkg::MODE_NONE;
                        n_shown   = '0;
                        n_written = 1'b1;
                    end
                    rlbps_pkg::REQ_COUNTDOWN, rlbps_pkg::REQ_SUCCESS,
                    rlbps_pkg::REQ_ERROR: begin
                        n_start  = r_clock;
                        n_last   = r_clock;
                        n_toggle = 1'b0;
                        if (r_req.req_type == rlbps_pkg::REQ_COUNTDOWN) begin
                            n_mode   = rlbps_pkg::MODE_COUNTDOWN;
                            n_length = r_req.duration_ms;
                        end else if (r_req.req_type == rlbps_pkg::REQ_SUCCESS) begin
                            n_mode   = rlbps_pkg::MODE_SUCCESS;
                            n_length = r_req.duration_ms;
                        end else begin
                            n_mode   = rlbps_pkg::MODE_ERROR;
                            n_length = '0;
                        end
                    end
                    default: ;
                endcase
            end
            rlbps_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_interval = (div_rsp.quot >= rlbps_pkg::CD_SPAN_MS)
                               ? rlbps_pkg::CD_MIN_MS
                               : rlbps_pkg::CD_START_MS - div_rsp.quot;
                    n_state    = rlbps_pkg::ST_TOGGLE;
                end
            end
            rlbps_pkg::ST_TOGGLE: begin
                n_state = rlbps_pkg::ST_DONE;
                if (since >= {{(rlbps_pkg::TIME_W-rlbps_pkg::INTERVAL_W){1'b0}}, r_interval}) begin
                    n_last    = r_clock;
                    n_toggle  = ~r_toggle;
                    n_written = 1'b1;
                    case (r_mode)
                        rlbps_pkg::MODE_COUNTDOWN: n_shown = n_toggle ? r_white : r_green;
                        rlbps_pkg::MODE_SUCCESS:   n_shown = n_toggle ? r_blue : r_green;
                        default:                   n_shown = n_toggle ? r_red : '0;
                    endcase
                end
            end
            rlbps_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.led_r          = r_shown[23:16];
                    n_out.led_g          = r_shown[15:8];
                    n_out.led_b          = r_shown[7:0];
                    n_out.color_written  = r_written;
                    n_out.pattern_active = (r_mode != rlbps_pkg::MODE_NONE);
                    n_out_valid          = 1'b1;
                    n_state              = rlbps_pkg::ST_IDLE;
                end
            end
            default: n_state = rlbps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlbps_pkg::ST_IDLE;
            r_mode      <= rlbps_pkg::MODE_NONE;
            r_clock     <= '0;
            r_start     <= '0;
            r_last      <= '0;
            r_length    <= '0;
            r_toggle    <= 1'b0;
            r_shown     <= '0;
            r_out_valid <= 1'b0;
            r_white     <= rlbps_pkg::WHITE_RST;
            r_green     <= rlbps_pkg::GREEN_RST;
            r_blue      <= rlbps_pkg::BLUE_RST;
            r_red       <= rlbps_pkg::RED_RST;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_clock     <= n_clock;
            r_start     <= n_start;
            r_last      <= n_last;
            r_length    <= n_length;
            r_toggle    <= n_toggle;
            r_shown     <= n_shown;
            r_out_valid <= n_out_valid;
            r_white     <= n_white;
            r_green     <= n_green;
            r_blue      <= n_blue;
            r_red       <= n_red;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_out      <= n_out;
        r_interval <= n_interval;
        r_written  <= n_written;
    end

    // divider only reports back while the sequencer waits for it
    `RLBPS_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, r_state == rlbps_pkg::ST_DIV)
    // the divider is never restarted while busy
    `RLBPS_ASSERT_IMP(a_div_no_restart, div_req.start, !div_rsp.busy)
    // error blink never carries a length
    `RLBPS_ASSERT_IMP(a_error_len_zero, r_mode == rlbps_pkg::MODE_ERROR, r_length == '0)
    // a finished request always lands in the output register and frees the input
    `RLBPS_ASSERT_NXT(a_done_publishes,
        (r_state == rlbps_pkg::ST_DONE) && (!r_out_valid || i_out_ready),
        o_out_valid && o_in_ready)

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// rgb led blink pattern sequencer testbench
// Runs a directed table, then random command and tick trains under four
// palettes. Each response is checked against a table entry or a cycle-free
// led model, with random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int RST_CYC     = 7;
    localparam int DRAIN_CYC   = 40;
    localparam int LIMIT_CYC   = 1_000_000;
    localparam int N_DIR       = 23;
    localparam int N_PHASE     = 4;
    localparam int PHASE_ITEMS = 475;

    // request codes the block ignores
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    // register indexes with no register behind them
    localparam logic [rlbps_pkg::CFG_ADDR_W-1:0] CFG_SPARE_LO = rlbps_pkg::CFG_ADDR_W'(4);
    localparam logic [rlbps_pkg::CFG_ADDR_W-1:0] CFG_SPARE_HI = rlbps_pkg::CFG_ADDR_W'(7);

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_HOLD
    } t_rx_style;

    typedef struct packed {
        rlbps_pkg::t_in_req  req;
        logic                typed;
        rlbps_pkg::t_out_rsp want;
    } t_dir_row;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_ready;
    rlbps_pkg::t_in_req               i_in        = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b1;
    rlbps_pkg::t_out_rsp              o_out;
    logic                             i_cfg_we    = 1'b0;
    logic [rlbps_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [rlbps_pkg::RGB_W-1:0]      i_cfg_data  = '0;

    // led model state
    logic [rlbps_pkg::TIME_W-1:0] ms_clock     = '0;
    rlbps_pkg::t_mode             run_mode     = rlbps_pkg::MODE_NONE;
    logic [rlbps_pkg::TIME_W-1:0] run_start_ms = '0;
    logic [rlbps_pkg::LEN_W-1:0]  run_len_ms   = '0;
    logic [rlbps_pkg::TIME_W-1:0] flip_ms      = '0;
    logic                         flip_on      = 1'b0;
    logic [rlbps_pkg::RGB_W-1:0]  led_rgb      = '0;
    logic [rlbps_pkg::RGB_W-1:0]  pal_rgb [4]  = '{rlbps_pkg::WHITE_RST, rlbps_pkg::GREEN_RST,
                                                   rlbps_pkg::BLUE_RST, rlbps_pkg::RED_RST};

    rlbps_pkg::t_out_rsp led_expect_q [$];
    t_dir_row            dir_rows [N_DIR];

    int items_sent   = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int burst_left   = 0;

    t_rx_style rx_style  = RX_OPEN;
    int        rx_left   = 0;
    int        rx_phase  = 0;
    int        rx_hold   = 0;

    rgb_led_blink_pattern_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYC) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // advances the led model by one request and returns the response it gives
    function automatic rlbps_pkg::t_out_rsp led_predict(input rlbps_pkg::t_in_req r);
        logic [rlbps_pkg::TIME_W-1:0] elapsed;
        logic [rlbps_pkg::TIME_W-1:0] since;
        logic [rlbps_pkg::TIME_W-1:0] step;
        logic [rlbps_pkg::TIME_W-1:0] interval;
        logic                         wrote;
        wrote = 1'b0;
        case (r.req_type)
            rlbps_pkg::REQ_TICK: begin
                ms_clock = ms_clock + 1;
                elapsed  = ms_clock - run_start_ms;
                since    = ms_clock - flip_ms;
                if (run_mode != rlbps_pkg::MODE_NONE) begin
                    if (run_mode != rlbps_pkg::MODE_ERROR
                        && elapsed >= rlbps_pkg::TIME_W'(run_len_ms)) begin
                        run_mode = rlbps_pkg::MODE_NONE;
                        led_rgb  = '0;
                        wrote    = 1'b1;
                    end else begin
                        if (run_mode == rlbps_pkg::MODE_COUNTDOWN) begin
                            // ceiling of span*elapsed/len, elapsed below len
                            step = rlbps_pkg::TIME_W'(rlbps_pkg::CD_SPAN_MS) * elapsed
                                 + rlbps_pkg::TIME_W'(run_len_ms) - 1;
                            step = step / rlbps_pkg::TIME_W'(run_len_ms);
                            if (step >= rlbps_pkg::TIME_W'(rlbps_pkg::CD_START_MS
                                                           - rlbps_pkg::CD_MIN_MS)) begin
                                interval = rlbps_pkg::TIME_W'(rlbps_pkg::CD_MIN_MS);
                            end else begin
                                interval = rlbps_pkg::TIME_W'(rlbps_pkg::CD_START_MS) - step;
                            end
                        end else if (run_mode == rlbps_pkg::MODE_SUCCESS) begin
                            interval = rlbps_pkg::TIME_W'(rlbps_pkg::SUCCESS_MS);
                        end else begin
                            interval = rlbps_pkg::TIME_W'(rlbps_pkg::ERROR_MS);
                        end
                        if (since >= interval) begin
                            flip_ms = ms_clock;
                            flip_on = ~flip_on;
                            wrote   = 1'b1;
                            case (run_mode)
                                rlbps_pkg::MODE_COUNTDOWN: begin
                                    led_rgb = flip_on ? pal_rgb[rlbps_pkg::CFG_WHITE]
                                                      : pal_rgb[rlbps_pkg::CFG_GREEN];
                                end
                                rlbps_pkg::MODE_SUCCESS: begin
                                    led_rgb = flip_on ? pal_rgb[rlbps_pkg::CFG_BLUE]
                                                      : pal_rgb[rlbps_pkg::CFG_GREEN];
                                end
                                default: begin
                                    led_rgb = flip_on ? pal_rgb[rlbps_pkg::CFG_RED] : '0;
                                end
                            endcase
                        end
                    end
                end
            end
            rlbps_pkg::REQ_SOLID: begin
                run_mode = rlbps_pkg::MODE_NONE;
                led_rgb  = {r.solid_r, r.solid_g, r.solid_b};
                wrote    = 1'b1;
            end
            rlbps_pkg::REQ_OFF: begin
                run_mode = rlbps_pkg::MODE_NONE;
                led_rgb  = '0;
                wrote    = 1'b1;
            end
            rlbps_pkg::REQ_COUNTDOWN, rlbps_pkg::REQ_SUCCESS, rlbps_pkg::REQ_ERROR: begin
                case (r.req_type)
                    rlbps_pkg::REQ_COUNTDOWN: run_mode = rlbps_pkg::MODE_COUNTDOWN;
                    rlbps_pkg::REQ_SUCCESS:   run_mode = rlbps_pkg::MODE_SUCCESS;
                    default:                  run_mode = rlbps_pkg::MODE_ERROR;
                endcase
                run_start_ms = ms_clock;
                run_len_ms   = (r.req_type == rlbps_pkg::REQ_ERROR) ? '0 : r.duration_ms;
                flip_ms      = ms_clock;
                flip_on      = 1'b0;
            end
            default: ;
        endcase
        return '{led_rgb[23:16], led_rgb[15:8], led_rgb[7:0], wrote,
                 run_mode != rlbps_pkg::MODE_NONE};
    endfunction

    function automatic rlbps_pkg::t_in_req rand_req(input logic [2:0] kind);
        rlbps_pkg::t_in_req r;
        r.req_type    = kind;
        r.duration_ms = rlbps_pkg::LEN_W'($urandom);
        r.solid_r     = 8'($urandom);
        r.solid_g     = 8'($urandom);
        r.solid_b     = 8'($urandom);
        return r;
    endfunction

    task automatic send_req(input rlbps_pkg::t_in_req r, input logic typed = 1'b0,
                            input rlbps_pkg::t_out_rsp want = '0);
        rlbps_pkg::t_out_rsp predicted;
        int                  gap;
        i_in       <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = led_predict(r);
        led_expect_q.push_back(typed ? want : predicted);
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hold off until every response is back and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic load_palette(input logic [rlbps_pkg::RGB_W-1:0] vals [4]);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            if (i < 4) begin
                i_cfg_addr <= rlbps_pkg::CFG_WHITE + rlbps_pkg::CFG_ADDR_W'(i);
                i_cfg_data <= vals[i];
            end else begin
                i_cfg_addr <= rlbps_pkg::CFG_ADDR_W'($urandom_range(CFG_SPARE_LO,
                                                                    CFG_SPARE_HI));
                i_cfg_data <= rlbps_pkg::RGB_W'($urandom);
            end
            @(posedge i_clk);
            if (i < 4) pal_rgb[rlbps_pkg::CFG_WHITE + i] = vals[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly one command, then a train of ticks, now and then broken by noise
    task automatic play_sequence(input int budget);
        int                 pick;
        int                 sel;
        int                 ticks;
        rlbps_pkg::t_in_req cmd;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        cmd  = rand_req(rlbps_pkg::REQ_TICK);
        if (sel < 25) cmd.duration_ms = rlbps_pkg::LEN_W'($urandom_range(0, 16));
        else if (sel < 80) cmd.duration_ms = rlbps_pkg::LEN_W'($urandom_range(17, 450));
        else if (sel < 93) cmd.duration_ms = rlbps_pkg::LEN_W'($urandom_range(451, 1000));
        ticks = $urandom_range(0, 40);
        if (pick < 60) begin
            cmd.req_type = (pick < 35) ? rlbps_pkg::REQ_COUNTDOWN : rlbps_pkg::REQ_SUCCESS;
            ticks = (cmd.duration_ms <= rlbps_pkg::LEN_W'(1000))
                  ? int'(cmd.duration_ms) + $urandom_range(0, 30) : $urandom_range(50, 400);
            // cut some runs short so the next command lands mid-pattern
            if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, ticks);
        end else if (pick < 72) begin
            cmd.req_type = rlbps_pkg::REQ_ERROR;
            ticks        = $urandom_range(100, 1100);
        end else if (pick < 82) begin
            cmd.req_type = rlbps_pkg::REQ_SOLID;
        end else if (pick < 88) begin
            cmd.req_type = rlbps_pkg::REQ_OFF;
        end else if (pick < 93) begin
            cmd.req_type = ($urandom_range(0, 1) != 0) ? REQ_SPARE6 : REQ_SPARE7;
        end
        // keep the phase close to its request count
        if (ticks >= budget) ticks = budget - 1;
        if (pick < 93) send_req(cmd);
        repeat (ticks) begin
            if ($urandom_range(0, 99) == 0) send_req(rand_req(3'($urandom_range(1, 7))));
            else send_req(rand_req(rlbps_pkg::REQ_TICK));
        end
    endtask

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        rlbps_pkg::t_out_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (led_expect_q.size() == 0) begin
                $error("response with no request waiting: 0x%0h", o_out);
                mismatch_cnt++;
            end else begin
                want = led_expect_q.pop_front();
                check_field("led_r", want.led_r, o_out.led_r);
                check_field("led_g", want.led_g, o_out.led_g);
                check_field("led_b", want.led_b, o_out.led_b);
                check_field("color_written", 8'(want.color_written), 8'(o_out.color_written));
                check_field("pattern_active", 8'(want.pattern_active),
                            8'(o_out.pattern_active));
            end
        end
    end

    // output back-pressure, switching among four styles at random
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(64, 400);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_style)
            RX_OPEN: i_out_ready <= 1'b1;
            RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
            RX_COMB: i_out_ready <= (rx_phase % 7) >= 3;
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 12);
                end
            end
        endcase
    end

    initial begin
        logic [rlbps_pkg::RGB_W-1:0] pal_next [4];
        int                          phase_end;
        dir_rows = '{
            '{'{rlbps_pkg::REQ_TICK,      16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
            '{'{REQ_SPARE6,               16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
            '{'{REQ_SPARE7,               16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
            '{'{rlbps_pkg::REQ_SOLID,     16'h0000, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
              '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0}},
            '{'{rlbps_pkg::REQ_SOLID,     16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
            '{'{rlbps_pkg::REQ_SOLID,     16'hFFFF, 8'h5A, 8'hC3, 8'h81}, 1'b1,
              '{8'h5A, 8'hC3, 8'h81, 1'b1, 1'b0}},
            '{'{rlbps_pkg::REQ_OFF,       16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
            // zero length pattern ends on the next tick
            '{'{rlbps_pkg::REQ_SUCCESS,   16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
            '{'{rlbps_pkg::REQ_TICK,      16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
            '{'{rlbps_pkg::REQ_COUNTDOWN, 16'hFFFF, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
            '{'{rlbps_pkg::REQ_TICK,      16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
            // error blink ignores the requested length
            '{'{rlbps_pkg::REQ_ERROR,     16'hFFFF, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
            '{'{rlbps_pkg::REQ_TICK,      16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
            '{'{rlbps_pkg::REQ_SOLID,     16'h0000, 8'h12, 8'h34, 8'h56}, 1'b1,
              '{8'h12, 8'h34, 8'h56, 1'b1, 1'b0}},
            // pattern start keeps the shown color
            '{'{rlbps_pkg::REQ_COUNTDOWN, 16'h0001, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h12, 8'h34, 8'h56, 1'b0, 1'b1}},
            '{'{rlbps_pkg::REQ_TICK,      16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
            '{'{rlbps_pkg::REQ_SUCCESS,   16'h0002, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
            '{'{rlbps_pkg::REQ_TICK,      16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
            '{'{rlbps_pkg::REQ_TICK,      16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
            '{'{rlbps_pkg::REQ_SOLID,     16'h0000, 8'hFF, 8'h00, 8'hFF}, 1'b1,
              '{8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0}},
            '{'{rlbps_pkg::REQ_ERROR,     16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1}},
            '{'{REQ_SPARE6,               16'h1234, 8'h11, 8'h22, 8'h33}, 1'b1,
              '{8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1}},
            '{'{rlbps_pkg::REQ_OFF,       16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}}
        };
        repeat (RST_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        for (int ph = 0; ph < N_PHASE; ph++) begin
            settle();
            case (ph)
                0:       pal_next = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};
                1:       pal_next = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000};
                2:       foreach (pal_next[k]) pal_next[k] = rlbps_pkg::RGB_W'($urandom);
                default: pal_next = '{rlbps_pkg::WHITE_RST, rlbps_pkg::GREEN_RST,
                                      rlbps_pkg::BLUE_RST, rlbps_pkg::RED_RST};
            endcase
            load_palette(pal_next);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                play_sequence(phase_end - items_sent);
                if ($urandom_range(0, 24) == 0) settle();
            end
        end
        settle();
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rlbps_pkg.sv
hw/rtl/rlbps_divider.sv
hw/rtl/rgb_led_blink_pattern_sequencer.sv
dv/testbench.sv
